FILE: sv/netstring_frame_encoder_unit_macros.svh
// Assertion macros shared by the framing encoder.
`ifndef NETSTRING_FRAME_ENCODER_UNIT_MACROS_SVH
`define NETSTRING_FRAME_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfe assertion failed");

`endif

FILE: sv/nfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nfe_pkg;

    localparam int CODE_W     = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_BITS   = BCD_DIGITS * 4;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_DATA  = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_stat;

    // Number of significant decimal digits, at least one.
    function automatic logic [3:0] f_digit_count(input t_bcd d);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (d[i] != 4'd0) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: sv/nfe_bcd_conv.sv
`timescale 1ns / 1ps
`default_nettype none
module nfe_bcd_conv (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [nfe_pkg::CODE_W-1:0] i_value,
    output nfe_pkg::t_conv_stat             o_stat,
    output nfe_pkg::t_bcd                   o_bcd
);
    import nfe_pkg::*;

    logic [CODE_W-1:0]   r_shift;
    t_bcd                r_bcd;
    logic [4:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    t_bcd                s_adj;
    logic [BCD_BITS-1:0] s_adj_flat;
    t_bcd                n_bcd;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            s_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    assign s_adj_flat = s_adj;
    assign n_bcd      = t_bcd'({s_adj_flat[BCD_BITS-2:0], r_shift[CODE_W-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(CODE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_bcd   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[CODE_W-2:0], 1'b0};
            r_bcd   <= n_bcd;
        end
    end

    assign o_stat = {r_busy, r_done};
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire

FILE: sv/netstring_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Netstring framing encoder: a start transfer (op 0) emits the header "len:code " (or
// "len:code," for an empty payload), and each payload transfer (op 1) passes its byte
// through, followed by a closing comma after the last one; a payload transfer with no
// frame open yields one error byte. Before the first header byte of a start transfer,
// the code and then the total length are each converted to decimal by one shared
// shift-and-add-3 unit that handles one bit per cycle; the header bytes then follow one
// per cycle while i_out_ready allows. The input is not ready while a header or a closing
// comma is being produced or the output register is held, and results leave through a
// single output register that stalls only on i_out_ready.
module netstring_frame_encoder_unit #(
    parameter int LEN_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_op,
    input  wire logic [31:0] i_code,
    input  wire logic [15:0] i_payload_length,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic             o_frame_end,
    output logic             o_error
);
    import nfe_pkg::*;

    `include "netstring_frame_encoder_unit_macros.svh"

    localparam int PW = (LEN_WIDTH < 16) ? LEN_WIDTH : 16;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CONV_CODE  = 4'd1;
    localparam logic [3:0] S_LOAD_TOTAL = 4'd2;
    localparam logic [3:0] S_CONV_TOTAL = 4'd3;
    localparam logic [3:0] S_EM_TOTAL   = 4'd4;
    localparam logic [3:0] S_EM_COLON   = 4'd5;
    localparam logic [3:0] S_EM_CODE    = 4'd6;
    localparam logic [3:0] S_EM_TERM    = 4'd7;
    localparam logic [3:0] S_COMMA      = 4'd8;

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [LEN_WIDTH-1:0] r_remain;
    logic [LEN_WIDTH-1:0] n_remain;
    logic [LEN_WIDTH-1:0] r_plen;
    logic [LEN_WIDTH-1:0] s_plen;
    t_bcd                 r_code_bcd;
    logic [3:0]           r_code_n;
    logic [3:0]           r_idx;
    logic [3:0]           n_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_last;
    logic                 r_frame_end;
    logic                 r_error;

    logic                 s_free;
    logic                 s_accept;
    logic                 s_start;
    logic [CODE_W-1:0]    s_value;
    logic [CODE_W-1:0]    s_total;
    t_conv_stat           s_stat;
    t_bcd                 s_bcd;
    logic                 s_emit;
    logic [7:0]           s_byte;
    logic                 s_last;
    logic                 s_fend;
    logic                 s_err;

    nfe_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_value (s_value),
        .o_stat  (s_stat),
        .o_bcd   (s_bcd)
    );

    assign s_free     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && s_free;
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_plen     = LEN_WIDTH'(i_payload_length[PW-1:0]);
    assign s_total    = CODE_W'(r_plen) + CODE_W'(r_plen != '0) + CODE_W'(r_code_n);
    assign s_start    = (s_accept && (i_op == OP_START)) || (r_state == S_LOAD_TOTAL);
    assign s_value    = (r_state == S_IDLE) ? i_code : s_total;

    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        n_idx    = r_idx;
        s_emit   = 1'b0;
        s_byte   = '0;
        s_last   = 1'b0;
        s_fend   = 1'b0;
        s_err    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_op == OP_START) begin
                        n_remain = s_plen;
                        n_state  = S_CONV_CODE;
                    end else if (r_remain == '0) begin
                        s_emit = 1'b1;
                        s_last = 1'b1;
                        s_err  = 1'b1;
                    end else begin
                        s_emit   = 1'b1;
                        s_byte   = i_data_byte;
                        n_remain = r_remain - LEN_WIDTH'(1);
                        if (r_remain == LEN_WIDTH'(1)) begin
                            n_state = S_COMMA;
                        end else begin
                            s_last = 1'b1;
                        end
                    end
                end
            end
            S_CONV_CODE: begin
                if (s_stat.done) begin
                    n_state = S_LOAD_TOTAL;
                end
            end
            S_LOAD_TOTAL: begin
                n_state = S_CONV_TOTAL;
            end
            S_CONV_TOTAL: begin
                if (s_stat.done) begin
                    n_idx   = f_digit_count(s_bcd) - 4'd1;
                    n_state = S_EM_TOTAL;
                end
            end
            S_EM_TOTAL: begin
                if (s_free) begin
                    s_emit = 1'b1;
                    s_byte = CH_ZERO + {4'd0, s_bcd[r_idx]};
                    n_idx  = r_idx - 4'd1;
                    if (r_idx == 4'd0) begin
                        n_state = S_EM_COLON;
                    end
                end
            end
            S_EM_COLON: begin
                if (s_free) begin
                    s_emit  = 1'b1;
                    s_byte  = CH_COLON;
                    n_idx   = r_code_n - 4'd1;
                    n_state = S_EM_CODE;
                end
            end
            S_EM_CODE: begin
                if (s_free) begin
                    s_emit = 1'b1;
                    s_byte = CH_ZERO + {4'd0, r_code_bcd[r_idx]};
                    n_idx  = r_idx - 4'd1;
                    if (r_idx == 4'd0) begin
                        n_state = S_EM_TERM;
                    end
                end
            end
            S_EM_TERM: begin
                if (s_free) begin
                    s_emit  = 1'b1;
                    s_last  = 1'b1;
                    n_state = S_IDLE;
                    if (r_plen != '0) begin
                        s_byte = CH_SPACE;
                    end else begin
                        s_byte = CH_COMMA;
                        s_fend = 1'b1;
                    end
                end
            end
            S_COMMA: begin
                if (s_free) begin
                    s_emit  = 1'b1;
                    s_byte  = CH_COMMA;
                    s_last  = 1'b1;
                    s_fend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (s_accept && (i_op == OP_START)) begin
            r_plen <= s_plen;
        end
        if ((r_state == S_CONV_CODE) && s_stat.done) begin
            r_code_bcd <= s_bcd;
            r_code_n   <= f_digit_count(s_bcd);
        end
        if (s_emit) begin
            r_out_byte  <= s_byte;
            r_last      <= s_last;
            r_frame_end <= s_fend;
            r_error     <= s_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;
    assign o_frame_end = r_frame_end;
    assign o_error     = r_error;

    `NFE_ASSERT_NEXT(a_orphan_error, i_clk, i_rst_n,
        s_accept && (i_op == OP_DATA) && (r_remain == '0),
        o_out_valid && o_error && o_last && (r_remain == '0))
    `NFE_ASSERT_NOW(a_frame_end_comma, i_clk, i_rst_n,
        o_out_valid && o_frame_end,
        o_last && (o_out_byte == CH_COMMA) && !o_error)
    `NFE_ASSERT_NOW(a_conv_only_in_conv, i_clk, i_rst_n,
        s_stat.busy,
        (r_state == S_CONV_CODE) || (r_state == S_CONV_TOTAL))

endmodule
`default_nettype wire

FILE: test/tb_netstring_frame_encoder_unit.sv
`timescale 1ns / 1ps
module tb_netstring_frame_encoder_unit;
    import nfe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 23;

    typedef struct {
        logic        op;
        logic [31:0] code;
        logic [15:0] plen;
        logic [7:0]  data;
        bit          drain;
    } t_frame_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic       frame_end;
        logic       error;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = OP_START;
    logic [31:0] i_code = '0;
    logic [15:0] i_payload_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_frame_end;
    logic        o_error;

    t_frame_item pending_items[$];
    t_frame_byte expected_bytes[$];
    t_frame_item current_item;
    logic [15:0] owed_bytes = '0;

    int cycle_count = 0;
    int accepted_count = 0;
    int start_count = 0;
    int payload_count = 0;
    int results_checked = 0;
    int frames_closed = 0;
    int error_results = 0;
    int mismatch_count = 0;
    bit gaps_on;

    netstring_frame_encoder_unit #(
        .LEN_WIDTH(16)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_code           (i_code),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last           (o_last),
        .o_frame_end      (o_frame_end),
        .o_error          (o_error)
    );

    always #1 i_clk = ~i_clk;

    // Both sides run without gaps for a stretch in the middle of the run.
    assign gaps_on = !(accepted_count >= 120 && accepted_count < 190);

    function automatic int decimal_width(input longint unsigned value);
        int n;
        n = 0;
        do begin
            value = value / 10;
            n++;
        end while (value != 0);
        return n;
    endfunction

    task automatic push_frame_byte(input logic [7:0] b, input logic fend, input logic err);
        t_frame_byte r;
        r.out_byte  = b;
        r.last      = 1'b0;
        r.frame_end = fend;
        r.error     = err;
        expected_bytes.insert(expected_bytes.size(), r);
    endtask

    task automatic push_decimal(input longint unsigned value);
        logic [7:0] rev[$];
        do begin
            rev.insert(rev.size(), CH_ZERO + 8'(value % 10));
            value = value / 10;
        end while (value != 0);
        while (rev.size() != 0) begin
            push_frame_byte(rev.pop_back(), 1'b0, 1'b0);
        end
    endtask

    task automatic predict_frame_bytes(input t_frame_item item);
        int code_len;
        int total;
        if (item.op == OP_START) begin
            code_len = decimal_width(item.code);
            total = int'(item.plen) + (item.plen != 0 ? 1 : 0) + code_len;
            push_decimal(total);
            push_frame_byte(CH_COLON, 1'b0, 1'b0);
            push_decimal(item.code);
            if (item.plen != 0) begin
                push_frame_byte(CH_SPACE, 1'b0, 1'b0);
            end else begin
                push_frame_byte(CH_COMMA, 1'b1, 1'b0);
            end
            owed_bytes = item.plen;
        end else if (owed_bytes == 0) begin
            push_frame_byte(8'h00, 1'b0, 1'b1);
        end else begin
            push_frame_byte(item.data, 1'b0, 1'b0);
            owed_bytes = owed_bytes - 1'b1;
            if (owed_bytes == 0) begin
                push_frame_byte(CH_COMMA, 1'b1, 1'b0);
            end
        end
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endtask

    task automatic queue_start(input logic [31:0] code, input logic [15:0] plen,
                               input bit drain);
        t_frame_item item;
        item.op    = OP_START;
        item.code  = code;
        item.plen  = plen;
        item.data  = 8'($urandom);
        item.drain = drain;
        pending_items.insert(pending_items.size(), item);
    endtask

    task automatic queue_payload(input logic [7:0] b);
        t_frame_item item;
        item.op    = OP_DATA;
        item.code  = $urandom;
        item.plen  = 16'($urandom);
        item.data  = b;
        item.drain = 1'b0;
        pending_items.insert(pending_items.size(), item);
    endtask

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 6))
                    0: return 32'd9;
                    1: return 32'd10;
                    2: return 32'd99;
                    3: return 32'd100;
                    4: return 32'd999999999;
                    5: return 32'd1000000000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 16'($urandom_range(0, 6));
        end else if (r < 97) begin
            return 16'($urandom_range(7, 40));
        end
        return 16'($urandom_range(80, 120));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_frame_bytes(current_item);
                accepted_count++;
                if (current_item.op == OP_START) begin
                    start_count++;
                end else begin
                    payload_count++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0
                        && !(pending_items[0].drain && expected_bytes.size() != 0)
                        && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                    current_item = pending_items.pop_front();
                    i_in_valid       <= 1'b1;
                    i_op             <= current_item.op;
                    i_code           <= current_item.code;
                    i_payload_length <= current_item.plen;
                    i_data_byte      <= current_item.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (o_frame_end && o_last) begin
                    frames_closed++;
                end
                if (o_error) begin
                    error_results++;
                end
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no transfer, got byte %h last %b end %b err %b",
                             $time, o_out_byte, o_last, o_frame_end, o_error);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.out_byte || o_last !== want.last
                            || o_frame_end !== want.frame_end || o_error !== want.error) begin
                        mismatch_count++;
                        $display("%0t: expected %h %b%b%b, got %h %b%b%b (byte last end err)",
                                 $time, want.out_byte, want.last, want.frame_end, want.error,
                                 o_out_byte, o_last, o_frame_end, o_error);
                    end
                end
            end
            i_out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int n;
        int plen;
        int sent;

        // Payload with no frame open, empty payload, widest fields and abandoned frames.
        queue_payload(8'hFF);
        queue_payload(8'h00);
        queue_start(32'd0, 16'd0, 1'b0);
        queue_start(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_payload(8'h00);
        queue_payload(8'hFF);
        queue_payload(8'hA5);
        queue_start(32'd123, 16'd1, 1'b0);
        queue_payload(8'h5A);
        queue_payload(8'h3C);
        queue_start(32'd1000000000, 16'd3, 1'b0);
        queue_payload(8'h11);
        queue_start(32'd7, 16'd7, 1'b0);
        queue_payload(8'h22);
        queue_payload(8'h33);
        queue_start(32'd42, 16'd2, 1'b1);
        queue_payload(8'h80);
        queue_payload(8'h01);
        queue_payload(8'h7F);
        queue_start(32'd99, 16'd8, 1'b0);
        for (int i = 0; i < 8; i++) begin
            queue_payload(8'(1 << i));
        end

        n = pending_items.size();
        while (n < 260) begin
            plen = pick_length();
            case ($urandom_range(0, 9))
                0: begin
                    queue_payload(8'($urandom));
                    n++;
                end
                1: begin
                    plen = $urandom_range(2, 10);
                    sent = $urandom_range(0, plen - 1);
                    queue_start(pick_code(), 16'(plen), 1'b0);
                    for (int i = 0; i < sent; i++) begin
                        queue_payload(8'($urandom));
                    end
                    n += sent + 1;
                end
                default: begin
                    queue_start(pick_code(), 16'(plen), n % 50 < 8);
                    for (int i = 0; i < plen; i++) begin
                        queue_payload(8'($urandom));
                    end
                    n += plen + 1;
                end
            endcase
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        $display("Run covered %0d frame starts and %0d payload transfers.",
                 start_count, payload_count);
        $display("Checked %0d output bytes: %0d closing commas, %0d error results.",
                 results_checked, frames_closed, error_results);
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

FILE: netstring_frame_encoder_unit.f
+incdir+sv
sv/nfe_pkg.sv
sv/nfe_bcd_conv.sv
sv/netstring_frame_encoder_unit.sv
test/tb_netstring_frame_encoder_unit.sv
